// ===== rtl/sfva_pkg.sv =====
// ----------------------------------------------------------------------------
// sfva_pkg
// Shared types and constants of the sound-effect voice allocator.
// ----------------------------------------------------------------------------
package sfva_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QDEPTH = 2;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_PLAY = 1'b1;

    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_UPDATE = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    typedef struct packed {
        logic        action;
        logic [15:0] start_hz;
        logic [15:0] end_hz;
        logic [15:0] length_ms;
        logic [7:0]  effect_priority;
        logic [7:0]  waveform;
        logic [7:0]  loudness;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  channel;
        logic [15:0] frequency_hz;
        logic [7:0]  wave_out;
        logic [7:0]  volume_out;
        logic        restore_song_voice;
        logic        last;
    } out_word_t;

    // Classified command handed from front to back.
    typedef struct packed {
        logic        is_play;
        logic        reject;
        logic [15:0] start_hz;
        logic [15:0] end_hz;
        logic [15:0] length_ms;
        logic [7:0]  effect_priority;
        logic [7:0]  waveform;
        logic [7:0]  loudness;
    } cmd_t;

endpackage

// ===== rtl/sfva_front.sv =====
// ----------------------------------------------------------------------------
// sfva_front
// Accept input words, flag zero-length plays, queue commands for the back end.
// ----------------------------------------------------------------------------
module sfva_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sfva_pkg::in_word_t in_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output sfva_pkg::cmd_t    cmd_data
);
    import sfva_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    cmd_t            q_mem [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;
    cmd_t            cmd_in;
    logic            push;
    logic            pop;

    always_comb
    begin
        cmd_in.is_play         = (in_data.action == ACT_PLAY);
        cmd_in.reject          = (in_data.length_ms == 16'd0);
        cmd_in.start_hz        = in_data.start_hz;
        cmd_in.end_hz          = in_data.end_hz;
        cmd_in.length_ms       = in_data.length_ms;
        cmd_in.effect_priority = in_data.effect_priority;
        cmd_in.waveform        = in_data.waveform;
        cmd_in.loudness        = in_data.loudness;
    end

    assign in_ready  = (count_reg != (PW+1)'(QDEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd_data  = q_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(QDEPTH))
        else $error("queue overflow");
    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == (PW+1)'(QDEPTH)) |-> !in_ready)
        else $error("accept while full");
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop count");
`endif

endmodule

// ===== rtl/sfva_div.sv =====
// ----------------------------------------------------------------------------
// sfva_div
// Restoring divider: 32-bit magnitude by 16-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module sfva_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] quo_reg;
    logic [16:0] rem_reg;
    logic [15:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] trial;
    logic [16:0] shifted;

    assign shifted  = {rem_reg[15:0], quo_reg[31]};
    assign trial    = shifted - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[16])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/sfva_back.sv =====
// ----------------------------------------------------------------------------
// sfva_back
// Slot table, channel choice on play, per-channel sweep on tick.
// ----------------------------------------------------------------------------
module sfva_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          song_voice_mask,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  sfva_pkg::cmd_t      cmd_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sfva_pkg::out_word_t out_data
);
    import sfva_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PICK, S_SCAN, S_MUL, S_DIV, S_EMIT
    } state_t;

    state_t            state_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [CH_W-1:0]   best_reg;
    logic              found_reg;
    logic              play_reg;
    cmd_t              cmd_reg;
    out_word_t         out_reg;
    logic              out_valid_reg;
    logic              pend_reg;
    out_word_t         pend_word_reg;
    logic [31:0]       mag_reg;
    logic              neg_reg;

    logic [CHANNELS-1:0] active_reg;
    logic [CHANNELS-1:0] restore_reg;
    logic [7:0]          prio_reg   [CHANNELS];
    logic [15:0]         start_reg  [CHANNELS];
    logic [15:0]         endhz_reg  [CHANNELS];
    logic [15:0]         len_reg    [CHANNELS];
    logic [15:0]         elap_reg   [CHANNELS];

    logic [CHANNELS-1:0] song_use;
    logic                found_a;
    logic                found_b;
    logic [CH_W-1:0]     ch_a;
    logic [CH_W-1:0]     ch_b;
    logic [15:0]         elap_inc;
    logic signed [16:0]  span;
    logic                div_start;
    logic                div_done;
    logic [31:0]         div_q;
    logic [16:0]         hz_sum;
    logic                last_ch;
    logic                more_after;

    sfva_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_reg),
        .divisor  (len_reg[ch_reg]),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            song_use[c] = (c < 8) ? song_voice_mask[c % 8] : 1'b0;
        end
        found_a = 1'b0;
        found_b = 1'b0;
        ch_a    = '0;
        ch_b    = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (!active_reg[c] && !song_use[c])
            begin
                found_a = 1'b1;
                ch_a    = CH_W'(c);
            end
            if (!active_reg[c])
            begin
                found_b = 1'b1;
                ch_b    = CH_W'(c);
            end
        end
    end

    assign elap_inc   = (elap_reg[ch_reg] < 16'hFFFF) ? elap_reg[ch_reg] + 16'd1
                                                      : elap_reg[ch_reg];
    assign span       = $signed({1'b0, endhz_reg[ch_reg]}) - $signed({1'b0, start_reg[ch_reg]});
    assign div_start  = (state_reg == S_MUL);
    assign last_ch    = (ch_reg == CH_W'(CHANNELS - 1));
    assign hz_sum     = neg_reg ? ({1'b0, start_reg[ch_reg]} - div_q[16:0])
                                : ({1'b0, start_reg[ch_reg]} + div_q[16:0]);
    assign more_after = ((active_reg >> ch_reg) >> 1) != '0;
    assign cmd_ready  = (state_reg == S_IDLE) && !pend_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    cmd_reg <= cmd_data;
                end
            end
            S_SCAN:
            begin
                if (!play_reg && active_reg[ch_reg] && !pend_reg)
                begin
                    elap_reg[ch_reg] <= elap_inc;
                end
                if (!active_reg[ch_reg] && play_reg && found_reg)
                begin
                    start_reg[best_reg] <= cmd_reg.start_hz;
                    endhz_reg[best_reg] <= cmd_reg.end_hz;
                    len_reg[best_reg]   <= cmd_reg.length_ms;
                    elap_reg[best_reg]  <= 16'd0;
                end
            end
            S_PICK:
            begin
                if (found_reg)
                begin
                    start_reg[best_reg] <= cmd_reg.start_hz;
                    endhz_reg[best_reg] <= cmd_reg.end_hz;
                    len_reg[best_reg]   <= cmd_reg.length_ms;
                    elap_reg[best_reg]  <= 16'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            best_reg      <= '0;
            found_reg     <= 1'b0;
            play_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_word_reg <= '0;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            active_reg    <= '0;
            restore_reg   <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                prio_reg[c] <= 8'd0;
            end
        end
        else
        begin
            if (pend_reg && (!out_valid_reg || out_ready))
            begin
                out_reg       <= pend_word_reg;
                out_valid_reg <= 1'b1;
                pend_reg      <= 1'b0;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid && cmd_ready)
                    begin
                        ch_reg <= '0;
                        if (!cmd_data.is_play)
                        begin
                            play_reg  <= 1'b0;
                            state_reg <= S_SCAN;
                        end
                        else if (cmd_data.reject)
                        begin
                            pend_word_reg <= {KIND_REJECT, 3'd0, 16'd0, 8'd0, 8'd0,
                                              1'b0, 1'b1};
                            pend_reg      <= 1'b1;
                        end
                        else if (found_a || found_b)
                        begin
                            play_reg  <= 1'b1;
                            found_reg <= 1'b1;
                            best_reg  <= found_a ? ch_a : ch_b;
                            state_reg <= S_PICK;
                        end
                        else
                        begin
                            play_reg  <= 1'b1;
                            found_reg <= 1'b0;
                            best_reg  <= '0;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (play_reg)
                    begin
                        // steal search: strict lower priority, lowest index on tie
                        if (prio_reg[ch_reg] < cmd_reg.effect_priority &&
                            (!found_reg || prio_reg[ch_reg] < prio_reg[best_reg]))
                        begin
                            found_reg <= 1'b1;
                            best_reg  <= ch_reg;
                        end
                        if (last_ch)
                        begin
                            state_reg <= S_PICK;
                        end
                        else
                        begin
                            ch_reg <= ch_reg + 1'b1;
                        end
                    end
                    else if (!active_reg[ch_reg])
                    begin
                        if (last_ch)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            ch_reg <= ch_reg + 1'b1;
                        end
                    end
                    else if (!pend_reg)
                    begin
                        if (elap_inc >= len_reg[ch_reg])
                        begin
                            active_reg[ch_reg] <= 1'b0;
                            pend_word_reg      <= {KIND_END, 3'(ch_reg), 16'd0, 8'd0, 8'd0,
                                                   restore_reg[ch_reg] &&
                                                   (song_voice_mask != 8'd0),
                                                   !more_after};
                            pend_reg           <= 1'b1;
                            if (last_ch || !more_after)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                ch_reg <= ch_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            neg_reg   <= span[16];
                            mag_reg   <= 32'(span[16] ? -span : span) * 32'(elap_inc);
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!pend_reg)
                    begin
                        pend_word_reg <= {KIND_UPDATE, 3'(ch_reg), hz_sum[15:0], 8'd0, 8'd0,
                                          1'b0, !more_after};
                        pend_reg      <= 1'b1;
                        if (last_ch || !more_after)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_PICK:
                begin
                    pend_reg <= 1'b1;
                    if (found_reg)
                    begin
                        active_reg[best_reg]  <= 1'b1;
                        prio_reg[best_reg]    <= cmd_reg.effect_priority;
                        restore_reg[best_reg] <= song_use[best_reg];
                        pend_word_reg         <= {KIND_ACCEPT, 3'(best_reg), cmd_reg.start_hz,
                                                  cmd_reg.waveform, cmd_reg.loudness,
                                                  1'b0, 1'b1};
                    end
                    else
                    begin
                        pend_word_reg <= {KIND_REJECT, 3'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b1};
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("result dropped under stall");
    a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !cmd_ready)
        else $error("command taken while busy");
    a_pick_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK && found_reg) |=> active_reg[$past(best_reg)])
        else $error("allocated slot not active");
`endif

endmodule

// ===== rtl/sound_effect_voice_allocator.sv =====
// ----------------------------------------------------------------------------
// sound_effect_voice_allocator
// Sound-effect channel allocator with priority stealing and linear sweeps.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries a tick or play word; output channel
// out_valid/out_ready carries result words, the final one of each input
// flagged by last. song_voice_mask_we writes the song channel mask.
// A front stage queues up to two classified words; the back end runs one
// word at a time. A play with a free channel goes through the pick state;
// one rejected for zero length is flagged directly from idle; with no free
// channel a steal search over every channel comes first. A tick walks the
// channels up to the last active one: idle and ending channels are handled
// in S_SCAN, a sweeping one goes through the bit-serial 32-bit divider.
// Reset frees all slots and clears priorities and the mask; no output is pending.
// When the receiver stalls, one result is held in the output register and
// one more waits in a pending stage; the back end then waits and the
// front queue fills before in_ready drops.
// ----------------------------------------------------------------------------
module sound_effect_voice_allocator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sfva_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sfva_pkg::out_word_t out_data,
    input  logic                song_voice_mask_we,
    input  logic [7:0]          song_voice_mask_wdata
);
    import sfva_pkg::*;

    logic       cmd_valid;
    logic       cmd_ready;
    cmd_t       cmd_data;
    logic [7:0] mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= 8'd0;
        end
        else if (song_voice_mask_we)
        begin
            mask_reg <= song_voice_mask_wdata;
        end
    end

    sfva_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data)
    );

    sfva_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .song_voice_mask (mask_reg),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd_data        (cmd_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data)
    );

endmodule
